[rtl/timer_slot_pool_macros.svh]
// Assertion macros used by the timer slot pool checker.
`ifndef TIMER_SLOT_POOL_MACROS_SVH
`define TIMER_SLOT_POOL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer_slot_pool assertion failed");

// Next-cycle implication, checked outside reset.
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer_slot_pool assertion failed");

`endif

[rtl/tsp_pkg.sv]
// Package: sizes, request codes and memory port type of the timer slot pool.
package tsp_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int TIME_W     = 32;
    localparam int SLOT_IN_W  = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int PURGED_W   = 5;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    localparam logic [SLOT_W-1:0] LAST_SLOT        = SLOT_W'(NUM_TIMERS - 1);
    localparam logic [TIME_W-1:0] ORPHAN_THR_RESET = TIME_W'(1000);

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_TIME = 2'd0,
        MODE_START    = 2'd1,
        MODE_CHECK    = 2'd2,
        MODE_CANCEL   = 2'd3
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [TIME_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

endpackage

[rtl/tsp_deadline_ram.sv]
// Deadline memory: one write port, one read port with registered read data.
module tsp_deadline_ram
    import tsp_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [TIME_W-1:0] o_rdata
);

    logic [TIME_W-1:0] r_mem [NUM_TIMERS];
    logic [TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tsp_ctrl.sv]
// Request sequencer: slot scan, purge sweep, expiry check and result register.
module tsp_ctrl
    import tsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TIME_W-1:0]     i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_mode                 i_mode,
    input  logic [TIME_W-1:0]     i_time_now,
    input  logic [TIME_W-1:0]     i_duration,
    input  logic [SLOT_IN_W-1:0]  i_slot_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SLOT_OUT_W-1:0] o_slot_out,
    output logic                  o_status,
    output logic                  o_finished,
    output logic [PURGED_W-1:0]   o_purged_count,
    output t_ram_req              o_ram_req,
    input  logic [TIME_W-1:0]     i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PURGE,
        S_PURGE_TAIL,
        S_CLAIM,
        S_CHK_RD,
        S_CHK_EV,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [NUM_TIMERS-1:0]   r_active;
    logic [TIME_W-1:0]       r_cur;
    logic [TIME_W-1:0]       r_thr;
    logic [TIME_W-1:0]       r_deadline;
    logic [SLOT_W-1:0]       r_idx;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       r_ev_idx;
    logic                    r_ev_valid;
    logic [SLOT_W-1:0]       r_first;
    logic                    r_found;
    logic [CNT_W-1:0]        r_cnt;
    logic [SLOT_OUT_W-1:0]   r_res_slot;
    logic                    r_res_status;
    logic                    r_res_finished;
    logic [PURGED_W-1:0]     r_res_purged;
    logic                    r_out_valid;
    logic [SLOT_OUT_W-1:0]   r_out_slot;
    logic                    r_out_status;
    logic                    r_out_finished;
    logic [PURGED_W-1:0]     r_out_purged;

    logic [TIME_W:0]         n_sum;
    logic [TIME_W-1:0]       n_deadline;
    logic [TIME_W-1:0]       n_age;
    logic                    n_purge_hit;
    logic                    slot_ok;
    logic                    in_purge;

    assign n_sum      = {1'b0, r_cur} + {1'b0, i_duration};
    assign n_deadline = n_sum[TIME_W] ? '1 : n_sum[TIME_W-1:0];
    assign n_age      = r_cur - i_ram_rdata;
    assign in_purge   = (r_state == S_PURGE) || (r_state == S_PURGE_TAIL);
    assign n_purge_hit = in_purge && r_ev_valid && r_active[r_ev_idx] &&
                         (r_cur >= i_ram_rdata) && (n_age >= r_thr);
    assign slot_ok    = (32'(i_slot_in) < 32'(NUM_TIMERS));

    always_comb begin
        o_ram_req.we    = ((r_state == S_SCAN) && !r_active[r_idx]) ||
                          ((r_state == S_CLAIM) && r_found);
        o_ram_req.waddr = (r_state == S_SCAN) ? r_idx : r_first;
        o_ram_req.wdata = r_deadline;
        o_ram_req.raddr = (r_state == S_CHK_RD) ? r_slot : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_cur       <= '0;
            r_thr       <= ORPHAN_THR_RESET;
            r_out_valid <= 1'b0;
            r_ev_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (n_purge_hit) begin
                r_active[r_ev_idx] <= 1'b0;
                r_cnt              <= r_cnt + 1'b1;
                if (!r_found) begin
                    r_found <= 1'b1;
                    r_first <= r_ev_idx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res_slot     <= '0;
                        r_res_status   <= 1'b0;
                        r_res_finished <= 1'b0;
                        r_res_purged   <= '0;
                        r_idx          <= '0;
                        r_cnt          <= '0;
                        r_found        <= 1'b0;
                        r_ev_valid     <= 1'b0;
                        r_deadline     <= n_deadline;
                        r_slot         <= SLOT_W'(i_slot_in);
                        unique case (i_mode)
                            MODE_SET_TIME: begin
                                r_cur   <= i_time_now;
                                r_state <= S_DONE;
                            end
                            MODE_START: begin
                                r_state <= S_SCAN;
                            end
                            MODE_CHECK: begin
                                r_state <= slot_ok ? S_CHK_RD : S_DONE;
                            end
                            MODE_CANCEL: begin
                                if (slot_ok) begin
                                    r_active[SLOT_W'(i_slot_in)] <= 1'b0;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!r_active[r_idx]) begin
                        r_active[r_idx] <= 1'b1;
                        r_res_slot      <= SLOT_OUT_W'(r_idx);
                        r_state         <= S_DONE;
                    end else if (r_idx == LAST_SLOT) begin
                        r_idx   <= '0;
                        r_state <= S_PURGE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_PURGE: begin
                    r_ev_valid <= 1'b1;
                    r_ev_idx   <= r_idx;
                    if (r_idx == LAST_SLOT) begin
                        r_state <= S_PURGE_TAIL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_PURGE_TAIL: begin
                    r_state <= S_CLAIM;
                end
                S_CLAIM: begin
                    if (r_found) begin
                        r_active[r_first] <= 1'b1;
                        r_res_slot        <= SLOT_OUT_W'(r_first);
                        r_res_purged      <= PURGED_W'(r_cnt);
                    end else begin
                        r_res_status <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_CHK_RD: begin
                    r_state <= S_CHK_EV;
                end
                S_CHK_EV: begin
                    if (r_active[r_slot] && (r_cur >= i_ram_rdata)) begin
                        r_active[r_slot] <= 1'b0;
                        r_res_finished   <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_slot     <= r_res_slot;
                        r_out_status   <= r_res_status;
                        r_out_finished <= r_res_finished;
                        r_out_purged   <= r_res_purged;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_slot_out     = r_out_slot;
    assign o_status       = r_out_status;
    assign o_finished     = r_out_finished;
    assign o_purged_count = r_out_purged;

endmodule

[rtl/timer_slot_pool.sv]
// Top level: a pool of one-shot timers over a 32-bit tick clock, one request
// per stream item and one result per request. Requests are taken one at a time.
// A start looks for a free slot with the slot scan, which tests one slot a cycle,
// and when the pool is full runs a purge sweep, to which the deadline memory
// gives one read a cycle. A new request is taken as soon as the previous result
// sits in the output register, even while it is still stalled.
module timer_slot_pool
    import tsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TIME_W-1:0]     i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // time_now [31:0], duration [63:32], slot_in [67:64], zero [71:68]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode [1:0]
    input  logic [MODE_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot_out [3:0], status [4], finished [5], purged_count [10:6], zero [15:11]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_ram_req              ram_req;
    logic [TIME_W-1:0]     ram_rdata;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic                  status;
    logic                  finished;
    logic [PURGED_W-1:0]   purged_count;

    tsp_deadline_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    tsp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_mode         (t_mode'(s_axis_tuser)),
        .i_time_now     (s_axis_tdata[31:0]),
        .i_duration     (s_axis_tdata[63:32]),
        .i_slot_in      (s_axis_tdata[67:64]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_slot_out     (slot_out),
        .o_status       (status),
        .o_finished     (finished),
        .o_purged_count (purged_count),
        .o_ram_req      (ram_req),
        .i_ram_rdata    (ram_rdata)
    );

    assign m_axis_tdata = {5'd0, purged_count, finished, status, slot_out};

endmodule

[rtl/tsp_checker.sv]
// Port checker for the timer slot pool and its bind to the top level.
`include "timer_slot_pool_macros.svh"

module tsp_checker
    import tsp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    `TSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TSP_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TSP_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[4], (m_axis_tdata[3:0] == 4'd0) && (m_axis_tdata[10:5] == 6'd0))
    `TSP_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0)

endmodule

bind timer_slot_pool tsp_checker u_tsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/timer_slot_pool_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for timer_slot_pool: a directed request table, then random phases.
module timer_slot_pool_test;
    import tsp_pkg::*;

    typedef struct packed {
        t_mode                mode;
        logic [TIME_W-1:0]    time_now;
        logic [TIME_W-1:0]    duration;
        logic [SLOT_IN_W-1:0] slot_in;
    } t_timer_req;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_out;
        logic                  status;
        logic                  finished;
        logic [PURGED_W-1:0]   purged;
    } t_timer_res;

    typedef struct packed {
        t_timer_req req;
        logic [4:0] reps;
        logic       fixed;
        t_timer_res res;
    } t_row;

    localparam int N_ROWS        = 22;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 230;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [TIME_W-1:0] T_MAX = 32'hFFFF_FFFF;

    localparam t_timer_res RES_IDLE    = '{4'd0, 1'b0, 1'b0, 5'd0};
    localparam t_timer_res RES_EXPIRED = '{4'd0, 1'b0, 1'b1, 5'd0};
    localparam t_timer_res RES_FULL    = '{4'd0, 1'b1, 1'b0, 5'd0};
    localparam t_timer_res RES_SLOT1   = '{4'd1, 1'b0, 1'b0, 5'd0};
    localparam t_timer_res RES_PURGED  = '{4'd0, 1'b0, 1'b0, 5'd16};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [TIME_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = MODE_SET_TIME;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [TIME_W-1:0] now_ticks;
    logic [TIME_W-1:0] purge_age;
    logic              busy    [NUM_TIMERS];
    logic [TIME_W-1:0] due     [NUM_TIMERS];
    logic              touched [NUM_TIMERS];
    t_timer_res        outcome_q [$];
    int                fail_count = 0;
    bit                hold_req   = 1'b0;

    t_row dir_rows [N_ROWS] = '{
        '{'{MODE_SET_TIME, 32'd0,    32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd0},  5'd1,  1'b1, RES_EXPIRED},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    T_MAX,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_SET_TIME, T_MAX,    32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    T_MAX,   4'd0},  5'd1,  1'b1, RES_SLOT1},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd1},  5'd1,  1'b1, RES_EXPIRED},
        '{'{MODE_CANCEL,   32'd0,    32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_SET_TIME, 32'd100,  32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    32'd0,   4'd0},  5'd16, 1'b0, RES_IDLE},
        '{'{MODE_START,    32'd0,    32'd5,   4'd0},  5'd1,  1'b1, RES_FULL},
        '{'{MODE_SET_TIME, 32'd1099, 32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    32'd5,   4'd0},  5'd1,  1'b1, RES_FULL},
        '{'{MODE_SET_TIME, 32'd1100, 32'd0,   4'd0},  5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    32'd7,   4'd0},  5'd1,  1'b1, RES_PURGED},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd15}, 5'd1,  1'b1, RES_IDLE},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd0},  5'd1,  1'b0, RES_IDLE},
        '{'{MODE_CANCEL,   32'd0,    32'd0,   4'd15}, 5'd1,  1'b1, RES_IDLE},
        '{'{MODE_START,    32'd0,    32'd3,   4'd0},  5'd1,  1'b0, RES_IDLE},
        '{'{MODE_CHECK,    32'd0,    32'd0,   4'd10}, 5'd1,  1'b1, RES_IDLE}
    };

    timer_slot_pool u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int lowest_free();
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!busy[i]) return i;
        end
        return -1;
    endfunction

    function automatic t_timer_res pool_outcome(t_timer_req r);
        t_timer_res      res;
        int              slot;
        int              n_purged;
        logic [TIME_W:0] sum;
        res = '0;
        case (r.mode)
            MODE_SET_TIME: begin
                now_ticks = r.time_now;
            end
            MODE_START: begin
                n_purged = 0;
                slot = lowest_free();
                if (slot < 0) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (busy[i] && now_ticks >= due[i] && now_ticks - due[i] >= purge_age) begin
                            busy[i] = 1'b0;
                            n_purged++;
                        end
                    end
                    slot = lowest_free();
                end
                if (slot >= 0) begin
                    sum = {1'b0, now_ticks} + {1'b0, r.duration};
                    busy[slot] = 1'b1;
                    touched[slot] = 1'b1;
                    due[slot] = sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
                    res.slot_out = SLOT_OUT_W'(slot);
                    res.purged = PURGED_W'(n_purged);
                end else begin
                    res.status = 1'b1;
                end
            end
            MODE_CHECK: begin
                if (int'(r.slot_in) < NUM_TIMERS && busy[r.slot_in] &&
                    now_ticks >= due[r.slot_in]) begin
                    busy[r.slot_in] = 1'b0;
                    res.finished = 1'b1;
                end
            end
            default: begin
                if (int'(r.slot_in) < NUM_TIMERS) busy[r.slot_in] = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic random_req(output t_timer_req r);
        int p;
        int q;
        int cands [$];
        p = $urandom_range(0, 99);
        q = $urandom_range(0, 99);
        r.time_now = $urandom;
        r.duration = $urandom;
        r.slot_in = SLOT_IN_W'($urandom_range(0, 15));
        if (p < 40) begin
            r.mode = MODE_START;
            if (q < 70) begin
                r.duration = $urandom_range(0, 40);
            end else if (q >= 85) begin
                case ($urandom_range(0, 2))
                    0: r.duration = '0;
                    1: r.duration = T_MAX;
                    default: r.duration = T_MAX - $urandom_range(0, 40);
                endcase
            end
        end else if (p < 65) begin
            r.mode = MODE_SET_TIME;
            if (q < 80) r.time_now = now_ticks + $urandom_range(0, 60);
            else if (q >= 90) r.time_now = $urandom_range(0, 1) ? T_MAX : '0;
        end else if (p < 90) begin
            r.mode = MODE_CHECK;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (busy[i]) cands.push_back(i);
            end
            if (cands.size() == 0 || q < 20) begin
                cands.delete();
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (touched[i]) cands.push_back(i);
                end
            end
            if (cands.size() == 0) begin
                r.mode = MODE_CANCEL;
            end else begin
                r.slot_in = SLOT_IN_W'(cands[$urandom_range(0, cands.size() - 1)]);
            end
        end else begin
            r.mode = MODE_CANCEL;
        end
    endtask

    task automatic offer(input t_timer_req r, input logic fixed, input t_timer_res fixed_res);
        t_timer_res res;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.mode;
        s_axis_tdata  <= {4'b0, r.slot_in, r.duration, r.time_now};
        do @(posedge i_clk); while (!s_axis_tready);
        res = pool_outcome(r);
        outcome_q.push_back(fixed ? fixed_res : res);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_pool();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [TIME_W-1:0] v);
        drain_pool();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        purge_age = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                $error("result with nothing pending: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = outcome_q.pop_front();
                check_field("slot_out", 32'(want.slot_out), 32'(m_axis_tdata[3:0]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[4]));
                check_field("finished", 32'(want.finished), 32'(m_axis_tdata[5]));
                check_field("purged_count", 32'(want.purged), 32'(m_axis_tdata[10:6]));
            end
        end
    end

    initial begin
        int run;
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("timer_slot_pool: mismatch");
        $finish;
    end

    initial begin
        t_timer_req        r;
        logic [TIME_W-1:0] thr_list [RAND_PHASES];
        now_ticks = '0;
        purge_age = ORPHAN_THR_RESET;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            busy[i]    = 1'b0;
            due[i]     = '0;
            touched[i] = 1'b0;
        end
        thr_list[0] = '0;
        thr_list[1] = 32'd25;
        thr_list[2] = ORPHAN_THR_RESET;
        thr_list[3] = T_MAX;
        thr_list[4] = $urandom_range(0, 300);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_ROWS; k++) begin
            for (int n = 0; n < dir_rows[k].reps; n++) begin
                offer(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].res);
                idle_sender(pick_gap());
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_threshold(thr_list[ph]);
            // keep offering back to back while the receiver holds off
            if (ph == 1) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_req(r);
                offer(r, 1'b0, RES_IDLE);
                if (ph != 1) idle_sender(pick_gap());
            end
        end

        drain_pool();
        if (fail_count == 0) begin
            $display("timer_slot_pool: match");
        end else begin
            $display("timer_slot_pool: mismatch");
        end
        $finish;
    end

endmodule
